### rtl/core/xlb_pkg.sv
// Package for the XOR linear basis unit: sizes, operation codes, datapath commands and status.
// Used by xlb_ctrl, xlb_dp and xor_linear_basis_unit.
package xlb_pkg;
  localparam int Slots = 32;
  localparam int IdxW  = 5;
  localparam int CntW  = 6;
  localparam int VecW  = 32;

  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_CONTAINS = 3'd1;
  localparam logic [2:0] OP_KSMALL   = 3'd2;
  localparam logic [2:0] OP_KLARGE   = 3'd3;
  localparam logic [2:0] OP_REPR     = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;

  typedef struct packed {
    logic          load;
    logic          rd_en;
    logic [IdxW-1:0] rd_idx;
    logic          step_reduce;
    logic          step_pick;
    logic          step_fix;
    logic          step_shift;
    logic          place;
    logic          emit_read;
    logic          emit_final;
  } xlb_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            rem_zero;
    logic [CntW-1:0] pos;
  } xlb_sts_t;
endpackage

### rtl/core/xlb_dp.sv
// Datapath of the XOR linear basis unit: entry memory, working registers and result word.
// Depends on xlb_pkg; driven by xlb_ctrl commands.
module xlb_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  xlb_pkg::xlb_cmd_t           cmd,
  output xlb_pkg::xlb_sts_t           sts,
  input  logic [2:0]                  in_op,
  input  logic [xlb_pkg::VecW-1:0]    in_value,
  input  logic [xlb_pkg::VecW-1:0]    in_rank,
  output logic [xlb_pkg::VecW-1:0]    res_value,
  output logic                        res_success,
  output logic [xlb_pkg::VecW-1:0]    res_mask,
  output logic                        res_range,
  output logic                        res_last
);
  logic [xlb_pkg::VecW-1:0] mem [xlb_pkg::Slots];
  logic [xlb_pkg::VecW-1:0] rd_r;
  logic [xlb_pkg::IdxW-1:0] idx_r;
  logic [xlb_pkg::CntW-1:0] count_r, count_nxt;
  logic [xlb_pkg::CntW-1:0] pos_r;
  logic                     pos_found_r;
  logic                     placed_r;
  logic [2:0]               op_r;
  logic [xlb_pkg::VecW-1:0] v_r, k_r, acc_r, mask_r;
  logic                     rng_r;
  logic [xlb_pkg::VecW-1:0] hi_mask;
  logic [xlb_pkg::VecW-1:0] wr_data;
  logic [xlb_pkg::IdxW-1:0] wr_idx;
  logic                     wr_en;
  logic [xlb_pkg::VecW-1:0] fixed;
  logic                     full;

  assign full = (count_r == 6'd32);
  always_comb begin
    hi_mask = '0;
    for (int b = 0; b < xlb_pkg::VecW; b++)
      if (v_r[b]) hi_mask = ~((32'd1 << b) - 32'd1);
  end
  assign fixed = ((rd_r ^ v_r) < rd_r) ? (rd_r ^ v_r) : rd_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_r <= mem[cmd.rd_idx];
    if (wr_en) mem[wr_idx] <= wr_data;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_idx = idx_r;
    wr_data = fixed;
    if (cmd.step_fix) begin
      wr_en = 1'b1;
    end else if (cmd.step_shift) begin
      wr_en = 1'b1; wr_idx = idx_r + 5'd1; wr_data = rd_r;
    end else if (cmd.place) begin
      wr_en = 1'b1; wr_idx = pos_r[xlb_pkg::IdxW-1:0]; wr_data = v_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.place) count_nxt = count_r + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else count_r <= count_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; v_r <= in_value; acc_r <= '0; mask_r <= '0;
      pos_r <= count_r; pos_found_r <= 1'b0; placed_r <= 1'b0;
      rng_r <= (count_r != 6'd32) && (in_rank >= (32'd1 << count_r[4:0]));
      if (in_op == xlb_pkg::OP_KLARGE)
        k_r <= (count_r == 6'd32) ? ~in_rank :
               ((32'd1 << count_r[4:0]) - 32'd1 - in_rank);
      else k_r <= in_rank;
    end else if (cmd.step_reduce) begin
      if ((v_r ^ rd_r) < v_r) begin
        v_r <= v_r ^ rd_r; mask_r <= mask_r | (32'd1 << idx_r);
      end
    end else if (cmd.step_pick) begin
      if (k_r[idx_r]) acc_r <= acc_r ^ rd_r;
    end else if (cmd.step_fix) begin
      if (!pos_found_r && ((fixed & hi_mask) != '0)) begin
        pos_found_r <= 1'b1; pos_r <= {1'b0, idx_r};
      end
    end else if (cmd.place) begin
      placed_r <= 1'b1;
    end
    // track the index of the entry held in rd_r
    if (cmd.rd_en) idx_r <= cmd.rd_idx;
  end

  always_comb begin
    res_value = '0; res_success = 1'b0; res_mask = '0; res_range = 1'b0; res_last = 1'b1;
    if (cmd.emit_read) begin
      res_value = rd_r;
      res_last = ({1'b0, idx_r} + 6'd1 == count_r);
    end else begin
      unique case (op_r)
        xlb_pkg::OP_INSERT:   res_success = placed_r;
        xlb_pkg::OP_CONTAINS: res_success = full || (v_r == '0);
        xlb_pkg::OP_KSMALL, xlb_pkg::OP_KLARGE: begin
          res_range = rng_r;
          res_value = rng_r ? '0 : acc_r;
        end
        xlb_pkg::OP_REPR: begin
          res_success = (v_r == '0);
          res_mask = (v_r == '0) ? mask_r : '0;
        end
        default: ;
      endcase
    end
  end

  assign sts.count = count_r;
  assign sts.rem_zero = (v_r == '0);
  assign sts.pos = pos_r;
endmodule

### rtl/core/xlb_ctrl.sv
// Controller of the XOR linear basis unit: sequences reduce, pick, fix, shift, place and emit steps.
// Depends on xlb_pkg; commands xlb_dp.
module xlb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        op,
  output logic              busy,
  output xlb_pkg::xlb_cmd_t cmd,
  input  xlb_pkg::xlb_sts_t sts,
  output logic              res_valid,
  input  logic              res_ready
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RUN = 3'd1, S_FIX = 3'd2, S_SHIFT = 3'd3,
                         S_OUT = 3'd4, S_READ = 3'd5;
  logic [2:0]  state_r, state_nxt;
  logic [2:0]  op_r;
  logic [6:0]  i_r, i_nxt;
  logic        rd_w;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    i_nxt = i_r;
    res_valid = 1'b0;
    rd_w = 1'b0;
    unique case (state_r)
      S_IDLE: if (start) begin
        cmd.load = 1'b1; i_nxt = '0;
        cmd.rd_en = 1'b1; cmd.rd_idx = '0;
        if (op == xlb_pkg::OP_READ)
          state_nxt = (sts.count == 6'd0) ? S_OUT : S_READ;
        else if (op == xlb_pkg::OP_INSERT && sts.count == 6'd32) state_nxt = S_OUT;
        else if (op > xlb_pkg::OP_READ) state_nxt = S_OUT;
        else state_nxt = S_RUN;
      end
      S_RUN: begin
        if (i_r[5:0] == sts.count) begin
          if (op_r == xlb_pkg::OP_INSERT && !sts.rem_zero) begin
            state_nxt = S_FIX; i_nxt = '0; cmd.rd_en = 1'b1; cmd.rd_idx = '0;
          end else state_nxt = S_OUT;
        end else begin
          if (op_r == xlb_pkg::OP_KSMALL || op_r == xlb_pkg::OP_KLARGE) cmd.step_pick = 1'b1;
          else cmd.step_reduce = 1'b1;
          i_nxt = i_r + 7'd1;
          cmd.rd_en = 1'b1; cmd.rd_idx = i_nxt[4:0];
        end
      end
      S_FIX: begin
        if (i_r[5:0] == sts.count) begin
          if (sts.pos == sts.count) begin
            cmd.place = 1'b1; state_nxt = S_OUT;
          end else begin
            state_nxt = S_SHIFT; i_nxt = {1'b0, sts.count} - 7'd1;
            cmd.rd_en = 1'b1; cmd.rd_idx = i_nxt[4:0];
          end
        end else begin
          cmd.step_fix = 1'b1; i_nxt = i_r + 7'd1;
          cmd.rd_en = 1'b1; cmd.rd_idx = i_nxt[4:0];
        end
      end
      S_SHIFT: begin
        if (i_r[5:0] + 6'd1 == sts.pos) begin
          cmd.place = 1'b1; state_nxt = S_OUT;
        end else begin
          cmd.step_shift = 1'b1; i_nxt = i_r - 7'd1;
          cmd.rd_en = 1'b1; cmd.rd_idx = i_nxt[4:0];
        end
        if (i_r[5:0] + 6'd1 == sts.pos) cmd.step_shift = 1'b0;
      end
      S_OUT: begin
        res_valid = 1'b1; cmd.emit_final = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      S_READ: begin
        res_valid = 1'b1; cmd.emit_read = 1'b1; rd_w = 1'b1;
        if (res_ready) begin
          i_nxt = i_r + 7'd1;
          cmd.rd_en = 1'b1; cmd.rd_idx = i_nxt[4:0];
          if (i_nxt[5:0] == sts.count) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (!rd_w && cmd.rd_en && cmd.emit_read) cmd.rd_en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; i_r <= '0; op_r <= '0;
    end else begin
      state_r <= state_nxt; i_r <= i_nxt;
      if (start && state_r == S_IDLE) op_r <= op;
    end
  end
endmodule

### rtl/core/xor_linear_basis_unit.sv
// XOR linear basis unit: sorted reduced GF(2) basis of up to 32 vectors.
// Read returns the basis one word per cycle while out_tready is high.
// One operation at a time: no new operation is accepted until the last result has been taken.
// Reset: synchronous active-low rst_n empties the basis (count to zero); entries are not cleared.
// Depends on xlb_pkg, xlb_ctrl and xlb_dp.
module xor_linear_basis_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // operation[2:0], value[34:3], rank[66:35], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // result_value[31:0], used_mask[63:32], basis_size[69:64]
  output logic [1:0]  out_tuser,  // success[0], range_error[1]
  output logic        out_tlast
);
  xlb_pkg::xlb_cmd_t cmd;
  xlb_pkg::xlb_sts_t sts;
  logic busy, start;
  logic [31:0] rv, rm;
  logic rs, rr, rl;

  assign in_tready = !busy;
  assign start = in_tvalid && in_tready;

  xlb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op(in_tdata[2:0]), .busy(busy),
    .cmd(cmd), .sts(sts), .res_valid(out_tvalid), .res_ready(out_tready)
  );

  xlb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_op(in_tdata[2:0]),
    .in_value(in_tdata[34:3]), .in_rank(in_tdata[66:35]), .res_value(rv),
    .res_success(rs), .res_mask(rm), .res_range(rr), .res_last(rl)
  );

  assign out_tdata = {2'b00, sts.count, rm, rv};
  assign out_tuser = {rr, rs};
  assign out_tlast = rl;

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n) sts.count <= 6'd32)
    else $error("basis count above capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> $stable(sts.count)) else $error("count moved while idle");
`endif
endmodule
